>>> hdl/vdl_pkg.sv
// ----------------------------------------------------------------------------
// vdl_pkg - shared types and constants for vertex diffuse lighting
// Fixed-point widths, register indexes, reset values and stage payloads.
// ----------------------------------------------------------------------------
package vdl_pkg;

    localparam int FRAC_BITS   = 14;
    localparam int COEF_W      = 16;
    localparam int VEC_W       = 3 * COEF_W;
    localparam int PROD_W      = 2 * COEF_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int ROT_W       = SUM_W - FRAC_BITS;
    localparam int LPROD_W     = ROT_W + COEF_W;
    localparam int DOT_W       = LPROD_W + 2;
    localparam int BYTE_W      = 8;
    localparam int COLOUR_W    = 3 * BYTE_W;
    localparam int SHADE_W     = DOT_W + BYTE_W;
    localparam int SHADE_SHIFT = 2 * FRAC_BITS;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COL0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COL1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COL2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_DIR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_COLOUR = 3'd4;

    localparam logic [VEC_W-1:0]    RST_MATRIX_COL0 = 48'd16384;
    localparam logic [VEC_W-1:0]    RST_MATRIX_COL1 = 48'd1073741824;
    localparam logic [VEC_W-1:0]    RST_MATRIX_COL2 = 48'd70368744177664;
    localparam logic [VEC_W-1:0]    RST_LIGHT_DIR   = 48'd240852556129523;
    localparam logic [COLOUR_W-1:0] RST_BASE_COLOUR = 24'hFFFFFF;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

    typedef logic [VEC_W-1:0] vec_t;

    typedef struct packed {
        logic signed [ROT_W-1:0] r0;
        logic signed [ROT_W-1:0] r1;
        logic signed [ROT_W-1:0] r2;
        logic                    last;
    } rot_t;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic                    last;
    } dot_t;

    function automatic logic signed [COEF_W-1:0] lane(input vec_t v, input int k);
        return $signed(v[COEF_W*k +: COEF_W]);
    endfunction

endpackage

>>> hdl/vdl_rotate.sv
// ----------------------------------------------------------------------------
// vdl_rotate - normal rotation stages
// Stage 1 registers the nine coefficient products, stage 2 sums each column
// and floors the sum back to the coefficient fraction.
// ----------------------------------------------------------------------------
module vdl_rotate
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_vld,
    output logic                              in_rdy,
    input  logic signed [vdl_pkg::COEF_W-1:0] nx,
    input  logic signed [vdl_pkg::COEF_W-1:0] ny,
    input  logic signed [vdl_pkg::COEF_W-1:0] nz,
    input  logic                              last,
    input  vdl_pkg::vec_t                     col0,
    input  vdl_pkg::vec_t                     col1,
    input  vdl_pkg::vec_t                     col2,
    output logic                              out_vld,
    input  logic                              out_rdy,
    output vdl_pkg::rot_t                     rot
);

    logic signed [vdl_pkg::PROD_W-1:0] prod_reg [3][3];
    logic                              last1_reg;
    logic                              v1_reg;
    logic                              v2_reg;
    logic                              rdy1;
    logic                              rdy2;
    vdl_pkg::rot_t                     rot_reg;
    vdl_pkg::rot_t                     rot_next;
    vdl_pkg::vec_t                     cols [3];
    logic signed [vdl_pkg::COEF_W-1:0] n [3];
    logic signed [vdl_pkg::SUM_W-1:0]  sum [3];

    assign cols[0] = col0;
    assign cols[1] = col1;
    assign cols[2] = col2;
    assign n[0]    = nx;
    assign n[1]    = ny;
    assign n[2]    = nz;

    assign rdy2   = !v2_reg || out_rdy;
    assign rdy1   = !v1_reg || rdy2;
    assign in_rdy = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_vld;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_vld)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[k][j] <= vdl_pkg::PROD_W'(vdl_pkg::lane(cols[k], j))
                                    * vdl_pkg::PROD_W'(n[j]);
                end
            end
            last1_reg <= last;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = vdl_pkg::SUM_W'(prod_reg[k][0]) + vdl_pkg::SUM_W'(prod_reg[k][1])
                   + vdl_pkg::SUM_W'(prod_reg[k][2]);
        end
        // floor to the coefficient fraction: keep the upper bits
        rot_next.r0   = sum[0][vdl_pkg::SUM_W-1:vdl_pkg::FRAC_BITS];
        rot_next.r1   = sum[1][vdl_pkg::SUM_W-1:vdl_pkg::FRAC_BITS];
        rot_next.r2   = sum[2][vdl_pkg::SUM_W-1:vdl_pkg::FRAC_BITS];
        rot_next.last = last1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            rot_reg <= rot_next;
        end
    end

    assign out_vld = v2_reg;
    assign rot     = rot_reg;

endmodule

>>> hdl/vdl_light_dot.sv
// ----------------------------------------------------------------------------
// vdl_light_dot - light direction dot product stages
// Stage 3 registers the three products with the light vector, stage 4 sums.
// ----------------------------------------------------------------------------
module vdl_light_dot
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    output logic          in_rdy,
    input  vdl_pkg::rot_t rot,
    input  vdl_pkg::vec_t light,
    output logic          out_vld,
    input  logic          out_rdy,
    output vdl_pkg::dot_t dot
);

    logic signed [vdl_pkg::LPROD_W-1:0] lprod_reg [3];
    logic signed [vdl_pkg::ROT_W-1:0]   r [3];
    logic                               last3_reg;
    logic                               v3_reg;
    logic                               v4_reg;
    logic                               rdy3;
    logic                               rdy4;
    vdl_pkg::dot_t                      dot_reg;
    vdl_pkg::dot_t                      dot_next;

    assign r[0] = rot.r0;
    assign r[1] = rot.r1;
    assign r[2] = rot.r2;

    assign rdy4   = !v4_reg || out_rdy;
    assign rdy3   = !v3_reg || rdy4;
    assign in_rdy = rdy3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
            begin
                v3_reg <= in_vld;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && in_vld)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lprod_reg[k] <= vdl_pkg::LPROD_W'(r[k]) * vdl_pkg::LPROD_W'(vdl_pkg::lane(light, k));
            end
            last3_reg <= rot.last;
        end
    end

    always_comb
    begin
        dot_next.dot  = vdl_pkg::DOT_W'(lprod_reg[0]) + vdl_pkg::DOT_W'(lprod_reg[1])
                      + vdl_pkg::DOT_W'(lprod_reg[2]);
        dot_next.last = last3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            dot_reg <= dot_next;
        end
    end

    assign out_vld = v4_reg;
    assign dot     = dot_reg;

endmodule

>>> hdl/vdl_shade.sv
// ----------------------------------------------------------------------------
// vdl_shade - colour scaling stages
// Stage 5 takes the magnitude of a negative dot, stage 6 scales it by each
// channel, stage 7 truncates and saturates into the output register.
// ----------------------------------------------------------------------------
module vdl_shade
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_vld,
    output logic                           in_rdy,
    input  vdl_pkg::dot_t                  dot,
    input  logic [vdl_pkg::COLOUR_W-1:0]   base,
    output logic                           out_vld,
    input  logic                           out_rdy,
    output logic [vdl_pkg::BYTE_W-1:0]     red,
    output logic [vdl_pkg::BYTE_W-1:0]     green,
    output logic [vdl_pkg::BYTE_W-1:0]     blue,
    output logic                           last
);

    logic [vdl_pkg::DOT_W-1:0]   mag_reg;
    logic [vdl_pkg::SHADE_W-1:0] scaled_reg [3];
    logic [vdl_pkg::SHADE_W-1:0] shifted [3];
    logic [vdl_pkg::BYTE_W-1:0]  byte_next [3];
    logic [vdl_pkg::BYTE_W-1:0]  byte_reg [3];
    logic                        last5_reg;
    logic                        last6_reg;
    logic                        last7_reg;
    logic                        v5_reg;
    logic                        v6_reg;
    logic                        v7_reg;
    logic                        rdy5;
    logic                        rdy6;
    logic                        rdy7;

    assign rdy7   = !v7_reg || out_rdy;
    assign rdy6   = !v6_reg || rdy7;
    assign rdy5   = !v5_reg || rdy6;
    assign in_rdy = rdy5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (rdy5)
            begin
                v5_reg <= in_vld;
            end
            if (rdy6)
            begin
                v6_reg <= v5_reg;
            end
            if (rdy7)
            begin
                v7_reg <= v6_reg;
            end
        end
    end

    // facing away from the light gives black
    always_ff @(posedge clk)
    begin
        if (rdy5 && in_vld)
        begin
            mag_reg   <= dot.dot[vdl_pkg::DOT_W-1] ? vdl_pkg::DOT_W'(-dot.dot)
                                                   : '0;
            last5_reg <= dot.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy6 && v5_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                scaled_reg[c] <= vdl_pkg::SHADE_W'(mag_reg)
                               * vdl_pkg::SHADE_W'(base[vdl_pkg::BYTE_W*c +: vdl_pkg::BYTE_W]);
            end
            last6_reg <= last5_reg;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            shifted[c]   = scaled_reg[c] >> vdl_pkg::SHADE_SHIFT;
            byte_next[c] = (|shifted[c][vdl_pkg::SHADE_W-1:vdl_pkg::BYTE_W])
                         ? vdl_pkg::BYTE_MAX : shifted[c][vdl_pkg::BYTE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy7 && v6_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                byte_reg[c] <= byte_next[c];
            end
            last7_reg <= last6_reg;
        end
    end

    assign out_vld = v7_reg;
    assign red     = byte_reg[0];
    assign green   = byte_reg[1];
    assign blue    = byte_reg[2];
    assign last    = last7_reg;

endmodule

>>> hdl/vertex_diffuse_lighting.sv
// ----------------------------------------------------------------------------
// vertex_diffuse_lighting - Lambert diffuse lighting of vertex normals
// One normal in, one lit colour out, through a seven-stage pipeline.
// ----------------------------------------------------------------------------
// Accepts one vertex normal per clock when not stalled by backpressure;
// throughput is one vertex per cycle, set by the seven register
// stages (products, column sums, light products, dot sum, magnitude,
// colour scale, saturate), each stage holding one vertex. Backpressure on
// the colour channel stalls only as far back as needed; empty stages keep
// filling. The config port is always ready; write it only while the
// pipeline is empty. Indexes above base_colour are ignored.
// ----------------------------------------------------------------------------
module vertex_diffuse_lighting
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vdl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vdl_pkg::VEC_W-1:0]           cfg_data,
    input  logic                                vertex_valid,
    output logic                                vertex_ready,
    input  logic signed [vdl_pkg::COEF_W-1:0]   normal_x,
    input  logic signed [vdl_pkg::COEF_W-1:0]   normal_y,
    input  logic signed [vdl_pkg::COEF_W-1:0]   normal_z,
    input  logic                                last_in,
    output logic                                colour_valid,
    input  logic                                colour_ready,
    output logic [vdl_pkg::BYTE_W-1:0]          red,
    output logic [vdl_pkg::BYTE_W-1:0]          green,
    output logic [vdl_pkg::BYTE_W-1:0]          blue,
    output logic                                last_out
);

    vdl_pkg::vec_t                  col0_reg;
    vdl_pkg::vec_t                  col1_reg;
    vdl_pkg::vec_t                  col2_reg;
    vdl_pkg::vec_t                  light_reg;
    logic [vdl_pkg::COLOUR_W-1:0]   base_reg;

    logic          rot_vld;
    logic          rot_rdy;
    vdl_pkg::rot_t rot;
    logic          dot_vld;
    logic          dot_rdy;
    vdl_pkg::dot_t dot;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col0_reg  <= vdl_pkg::RST_MATRIX_COL0;
            col1_reg  <= vdl_pkg::RST_MATRIX_COL1;
            col2_reg  <= vdl_pkg::RST_MATRIX_COL2;
            light_reg <= vdl_pkg::RST_LIGHT_DIR;
            base_reg  <= vdl_pkg::RST_BASE_COLOUR;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                vdl_pkg::REG_MATRIX_COL0: col0_reg  <= cfg_data;
                vdl_pkg::REG_MATRIX_COL1: col1_reg  <= cfg_data;
                vdl_pkg::REG_MATRIX_COL2: col2_reg  <= cfg_data;
                vdl_pkg::REG_LIGHT_DIR:   light_reg <= cfg_data;
                vdl_pkg::REG_BASE_COLOUR: base_reg  <= cfg_data[vdl_pkg::COLOUR_W-1:0];
                default:                  ;
            endcase
        end
    end

    vdl_rotate u_rotate
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (vertex_valid),
        .in_rdy  (vertex_ready),
        .nx      (normal_x),
        .ny      (normal_y),
        .nz      (normal_z),
        .last    (last_in),
        .col0    (col0_reg),
        .col1    (col1_reg),
        .col2    (col2_reg),
        .out_vld (rot_vld),
        .out_rdy (rot_rdy),
        .rot     (rot)
    );

    vdl_light_dot u_light_dot
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (rot_vld),
        .in_rdy  (rot_rdy),
        .rot     (rot),
        .light   (light_reg),
        .out_vld (dot_vld),
        .out_rdy (dot_rdy),
        .dot     (dot)
    );

    vdl_shade u_shade
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (dot_vld),
        .in_rdy  (dot_rdy),
        .dot     (dot),
        .base    (base_reg),
        .out_vld (colour_valid),
        .out_rdy (colour_ready),
        .red     (red),
        .green   (green),
        .blue    (blue),
        .last    (last_out)
    );

endmodule
